FILE: rtl/range_splitter_across_nodes_top_defines.svh
// assertion macros for the range splitter checker
`ifndef RANGE_SPLITTER_ACROSS_NODES_TOP_DEFINES_SVH
`define RANGE_SPLITTER_ACROSS_NODES_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define RSAN_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define RSAN_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

FILE: rtl/rsan_pkg.sv
// types, constants and helpers shared by the range splitter
`timescale 1ns / 1ps
package rsan_pkg;

	localparam int NODES = 4;
	localparam int NODE_SLOTS = 4;
	localparam int NODES_USED = (NODES < NODE_SLOTS) ? NODES : NODE_SLOTS;
	localparam int CFG_IDX_W = 3;
	localparam int Q_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_NODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_NODE0  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_NODE1  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_NODE2  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_END_NODE3  = 3'd6;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_CLIPPED   = 2'd2;

	typedef struct packed {
		logic [31:0] req_offset;
		logic [31:0] req_size;
	} req_t;

	typedef struct packed {
		logic [1:0]  node_index;
		logic [31:0] chunk_offset;
		logic [31:0] chunk_size;
		logic [31:0] buffer_offset;
		logic        is_local;
		logic [1:0]  status;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0]                 base_start;
		logic [2:0]                  node_count;
		logic [1:0]                  local_node;
		logic [NODE_SLOTS-1:0][31:0] end_node;
	} cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [31:0] off;
		logic [31:0] sz;
		logic [32:0] fence;
		logic [1:0]  node;
		logic        err;
	} entry_t;

	function automatic logic [2:0] nodes_in_use(input logic [2:0] node_count);
		logic [2:0] lim;
		lim = 3'(NODES_USED);
		return (node_count > lim) ? lim : node_count;
	endfunction

	function automatic logic [31:0] slice_start(input cfg_t cfg, input logic [1:0] k);
		return (k == 2'd0) ? cfg.base_start : cfg.end_node[k - 2'd1];
	endfunction

endpackage

FILE: rtl/rsan_front.sv
// front end: accepts requests and finds the first node holding the offset
`timescale 1ns / 1ps
module rsan_front (
	input  logic          in_valid,
	output logic          in_ready,
	input  rsan_pkg::req_t req,
	input  rsan_pkg::cfg_t cfg,
	input  logic          q_full,
	output logic          push,
	output rsan_pkg::entry_t entry
);
	import rsan_pkg::*;

	logic [2:0]            n_used;
	logic [NODE_SLOTS-1:0] hit;
	logic [1:0]            k;
	logic [31:0]           start;

	always_comb begin
		n_used = nodes_in_use(cfg.node_count);
		for (int i = 0; i < NODE_SLOTS; i++) begin
			hit[i] = (3'(i) < n_used) && (req.req_offset < cfg.end_node[i]);
		end
		k = 2'd0;
		for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				k = 2'(i);
			end
		end
		start = slice_start(cfg, k);
		entry.off   = req.req_offset;
		entry.sz    = req.req_size;
		entry.fence = {1'b0, req.req_offset} + {1'b0, req.req_size};
		entry.node  = k;
		entry.err   = !(|hit) || (req.req_offset < start);
		in_ready    = !q_full;
		push        = in_valid && !q_full;
	end

endmodule

FILE: rtl/rsan_queue.sv
// two-entry queue between the front and back ends
`timescale 1ns / 1ps
module rsan_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rsan_pkg::entry_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output rsan_pkg::entry_t pop_data
);
	import rsan_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	entry_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(Q_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/rsan_back.sv
// back end: walks the touched nodes and issues one chunk per cycle while the result channel is not stalled
`timescale 1ns / 1ps
module rsan_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rsan_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  rsan_pkg::entry_t q_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output rsan_pkg::res_t   res
);
	import rsan_pkg::*;

	entry_t      cur_q;
	logic [1:0]  k_q;
	logic [31:0] buf_q;
	logic        first_q;
	logic        busy_q;
	logic        out_valid_q;
	res_t        res_q;

	logic [2:0]  n_used;
	logic [31:0] start;
	logic [31:0] endv;
	logic        fits;
	logic        is_done;
	logic        advance;
	res_t        chunk;

	always_comb begin
		n_used = nodes_in_use(cfg.node_count);
		start  = slice_start(cfg, k_q);
		endv   = cfg.end_node[k_q];
		fits   = cur_q.fence <= {1'b0, endv};
		chunk.node_index    = k_q;
		chunk.chunk_offset  = first_q ? (cur_q.off - start) : '0;
		chunk.buffer_offset = buf_q;
		chunk.is_local      = (k_q == cfg.local_node);
		chunk.status        = ST_OK;
		if (fits) begin
			if (first_q) begin
				chunk.chunk_size = cur_q.sz;
			end else begin
				chunk.chunk_size = (cur_q.fence >= {1'b0, start}) ?
					32'(cur_q.fence - {1'b0, start}) : '0;
			end
			is_done = 1'b1;
		end else begin
			if (first_q) begin
				chunk.chunk_size = endv - cur_q.off;
			end else begin
				chunk.chunk_size = (endv > start) ? (endv - start) : '0;
			end
			is_done = ({1'b0, k_q} + 3'd1) >= n_used;
			if (is_done) begin
				chunk.status = ST_CLIPPED;
			end
		end
		if (cur_q.err) begin
			chunk   = '{node_index: 2'd0, chunk_offset: '0, chunk_size: '0,
				buffer_offset: '0, is_local: 1'b0, status: ST_NOT_FOUND, last: 1'b1};
			is_done = 1'b1;
		end
		chunk.last = is_done;
		advance = busy_q && (!out_valid_q || out_ready);
		pop     = q_valid && (!busy_q || (advance && is_done));
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && is_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= chunk;
		end
		if (pop) begin
			cur_q   <= q_data;
			k_q     <= q_data.node;
			buf_q   <= '0;
			first_q <= 1'b1;
		end else if (advance) begin
			k_q     <= k_q + 2'd1;
			buf_q   <= buf_q + chunk.chunk_size;
			first_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/range_splitter_across_nodes_top.sv
// top level of the range splitter: config registers, front, queue and back
`timescale 1ns / 1ps
// Splits a global byte range over up to four node slices. The front end takes
// a request, finds the first node holding the offset and places the request
// in a two-entry queue; the back end then issues one chunk per cycle while
// the result channel is not stalled, one per node touched (a single chunk
// for a failed lookup). A request moves from the queue into the back end
// when the back end is idle or is issuing the last chunk of the one before. The chunk
// walk in the back end sets the sustained rate. Config writes are taken at
// any time and must happen only while the block is idle.
module range_splitter_across_nodes_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rsan_pkg::req_t                    req,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rsan_pkg::res_t                    res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rsan_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);
	import rsan_pkg::*;

	cfg_t   cfg_q;
	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   q_valid;
	entry_t q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_start <= '0;
			cfg_q.node_count <= 3'd1;
			cfg_q.local_node <= '0;
			cfg_q.end_node   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASE_START: cfg_q.base_start  <= cfg_data;
				REG_NODE_COUNT: cfg_q.node_count  <= cfg_data[2:0];
				REG_LOCAL_NODE: cfg_q.local_node  <= cfg_data[1:0];
				REG_END_NODE0:  cfg_q.end_node[0] <= cfg_data;
				REG_END_NODE1:  cfg_q.end_node[1] <= cfg_data;
				REG_END_NODE2:  cfg_q.end_node[2] <= cfg_data;
				REG_END_NODE3:  cfg_q.end_node[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	rsan_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req      (req),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.entry    (push_entry)
	);

	rsan_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	rsan_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

endmodule

FILE: rtl/rsan_checker.sv
// port-level checks for the range splitter and their binding
`timescale 1ns / 1ps
`include "range_splitter_across_nodes_top_defines.svh"
module rsan_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input rsan_pkg::res_t res
);
	import rsan_pkg::*;

	`RSAN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res), "result changed while stalled")
	`RSAN_ASSERT_NOW(a_err_single, out_valid && (res.status == ST_NOT_FOUND), res.last && (res.chunk_size == 32'd0) && (res.node_index == 2'd0) && !res.is_local, "bad not-found result")
	`RSAN_ASSERT_NOW(a_clip_last, out_valid && (res.status == ST_CLIPPED), res.last, "clipped chunk not last")
	`RSAN_ASSERT_NOW(a_status_code, out_valid, (res.status == ST_OK) || (res.status == ST_NOT_FOUND) || (res.status == ST_CLIPPED), "unknown status")

endmodule

bind range_splitter_across_nodes_top rsan_checker u_rsan_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.res       (res)
);

FILE: bench/tb.sv
// self-checking bench for the range splitter: random handshakes, chunk prediction, compare
`timescale 1ns / 1ps
module tb;
	import rsan_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		req_t r;
		bit   drain;
	} pending_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic [31:0] cfg_base = '0;
	logic [2:0] cfg_count = 3'd1;
	logic [1:0] cfg_local = '0;
	logic [31:0] cfg_end [4] = '{default: '0};

	pending_t pending[$];
	res_t chunks_due[$];
	res_t want;
	int queued_n = 0;
	int taken_n = 0;
	int errors = 0;
	int stall_n = 0;
	bit in_acc = 1'b0;
	bit out_acc;
	bit steady = 1'b0;

	range_splitter_across_nodes_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req(req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] slice_base(input int k);
		return (k == 0) ? cfg_base : cfg_end[k - 1];
	endfunction

	// expected chunks of one request under the current register copy
	function automatic void split_range(input req_t r);
		logic [32:0] fence;
		logic [31:0] base_k;
		logic [31:0] end_k;
		logic [31:0] pos;
		int n;
		int k;
		bit first;
		bit done;
		res_t c;
		fence = {1'b0, r.req_offset} + {1'b0, r.req_size};
		n = (int'(cfg_count) > NODES_USED) ? NODES_USED : int'(cfg_count);
		k = 0;
		pos = '0;
		first = 1'b1;
		done = 1'b0;
		while (k < n && r.req_offset >= cfg_end[k]) k++;
		if (k >= n || r.req_offset < slice_base(k)) begin
			c = '0;
			c.status = ST_NOT_FOUND;
			c.last = 1'b1;
			chunks_due.push_back(c);
			return;
		end
		while (k < n && !done) begin
			base_k = slice_base(k);
			end_k = cfg_end[k];
			c = '0;
			c.node_index = 2'(k);
			c.chunk_offset = first ? r.req_offset - base_k : '0;
			c.status = ST_OK;
			if (fence <= {1'b0, end_k}) begin
				if (first)
					c.chunk_size = r.req_size;
				else
					c.chunk_size = (fence >= {1'b0, base_k}) ? 32'(fence - {1'b0, base_k}) : '0;
				done = 1'b1;
			end else begin
				if (first)
					c.chunk_size = end_k - r.req_offset;
				else
					c.chunk_size = (end_k > base_k) ? end_k - base_k : '0;
				if (k + 1 >= n) begin
					c.status = ST_CLIPPED;
					done = 1'b1;
				end
			end
			c.buffer_offset = pos;
			c.is_local = (2'(k) == cfg_local);
			c.last = done;
			chunks_due.push_back(c);
			pos = pos + c.chunk_size;
			first = 1'b0;
			k++;
		end
	endfunction

	function automatic req_t random_req();
		req_t r;
		int j;
		logic [31:0] lo;
		logic [31:0] span;
		if ($urandom_range(9) < 2) begin
			r.req_offset = $urandom;
			r.req_size = $urandom;
		end else begin
			j = $urandom_range(3);
			lo = slice_base(j);
			span = (cfg_end[j] > lo) ? cfg_end[j] - lo : 32'd1;
			r.req_offset = lo + ($urandom % span);
			r.req_size = ($urandom_range(7) == 0) ? $urandom :
				($urandom % span) + ($urandom_range(1) ? span : 32'd0);
		end
		return r;
	endfunction

	task automatic queue_item(input logic [31:0] off, input logic [31:0] sz, input bit drain = 1'b0);
		pending_t p;
		p.r.req_offset = off;
		p.r.req_size = sz;
		p.drain = drain;
		pending.push_back(p);
		queued_n++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_BASE_START: cfg_base = val;
			REG_NODE_COUNT: cfg_count = val[2:0];
			REG_LOCAL_NODE: cfg_local = val[1:0];
			REG_END_NODE0, REG_END_NODE1, REG_END_NODE2, REG_END_NODE3:
				cfg_end[int'(idx) - int'(REG_END_NODE0)] = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every request is taken and every chunk is back
	task automatic settle();
		while (taken_n != queued_n || chunks_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_setup();
		logic [32:0] mark;
		int w;
		int i;
		mark = ($urandom_range(3) == 0) ? {1'b0, $urandom} : 33'($urandom_range(4096));
		write_reg(REG_BASE_START, mark[31:0]);
		for (i = 0; i < 4; i++) begin
			w = $urandom_range(4, 30);
			if ($urandom_range(4) == 0) begin
				write_reg(3'(int'(REG_END_NODE0) + i), $urandom);
			end else begin
				mark = mark + ({1'b0, $urandom} & ((33'd1 << w) - 33'd1));
				if (mark > 33'hFFFF_FFFF)
					mark = 33'hFFFF_FFFF;
				write_reg(3'(int'(REG_END_NODE0) + i), mark[31:0]);
			end
		end
		write_reg(REG_NODE_COUNT, ($urandom & ~32'h7) |
			(($urandom_range(5) == 0) ? $urandom_range(7) : $urandom_range(1, 4)));
		write_reg(REG_LOCAL_NODE, ($urandom & ~32'h3) | $urandom_range(3));
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_acc) begin
				if (pending.size() > 0 && !(pending[0].drain && chunks_due.size() > 0) &&
						(steady || $urandom_range(99) >= 31)) begin
					req <= pending[0].r;
					in_valid <= 1'b1;
					void'(pending.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= steady || ($urandom_range(99) >= 31);
		end
	end

	// transfer monitor, chunk check and watchdog
	always @(posedge clk) begin
		in_acc = arst_n && in_valid && in_ready;
		out_acc = arst_n && out_valid && out_ready;
		if (in_acc) begin
			split_range(req);
			taken_n++;
		end
		if (out_acc) begin
			if (chunks_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected chunk node %0d off %h size %h buf %h local %0d st %0d last %0d",
					$time, res.node_index, res.chunk_offset, res.chunk_size,
					res.buffer_offset, res.is_local, res.status, res.last);
			end else begin
				want = chunks_due.pop_front();
				if (res !== want) begin
					errors++;
					$display("%0t: expected node %0d off %h size %h buf %h local %0d st %0d last %0d",
						$time, want.node_index, want.chunk_offset, want.chunk_size,
						want.buffer_offset, want.is_local, want.status, want.last);
					$display("%0t: actual   node %0d off %h size %h buf %h local %0d st %0d last %0d",
						$time, res.node_index, res.chunk_offset, res.chunk_size,
						res.buffer_offset, res.is_local, res.status, res.last);
				end
			end
		end
		if (in_acc || out_acc || (cfg_valid && cfg_ready))
			stall_n = 0;
		else
			stall_n++;
		if (stall_n >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		int ph;
		int i;
		req_t r;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: node zero ends at zero, so nothing is found
		queue_item(32'h0, 32'h0);
		queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		settle();

		write_reg(REG_BASE_START, 32'h1000);
		write_reg(REG_END_NODE0, 32'h2000);
		write_reg(REG_END_NODE1, 32'h3000);
		write_reg(REG_END_NODE2, 32'h4000);
		write_reg(REG_END_NODE3, 32'h5000);
		write_reg(REG_NODE_COUNT, 32'd4);
		write_reg(REG_LOCAL_NODE, 32'd1);
		queue_item(32'h0800, 32'h10);
		queue_item(32'h1000, 32'h0);
		queue_item(32'h1800, 32'h100);
		queue_item(32'h1800, 32'h1000);
		queue_item(32'h1000, 32'h4000);
		queue_item(32'h2FFF, 32'h2002);
		queue_item(32'h4800, 32'h1000);
		queue_item(32'h1000, 32'h1000);
		queue_item(32'h5000, 32'h1);
		queue_item(32'h4FFF, 32'hFFFF_FFFF);
		queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		settle();

		// decreasing boundaries, count above the node limit, unused index
		write_reg(REG_END_NODE0, 32'h3000);
		write_reg(REG_END_NODE1, 32'h2000);
		write_reg(REG_END_NODE3, 32'h1800);
		write_reg(REG_NODE_COUNT, 32'hFFFF_FFFF);
		write_reg(REG_LOCAL_NODE, 32'hFFFF_FFFF);
		write_reg(REG_NONE, 32'hDEAD_BEEF);
		queue_item(32'h1000, 32'h4000);
		queue_item(32'h2800, 32'h10);
		queue_item(32'h3800, 32'h900);
		queue_item(32'h1400, 32'h1C00);
		settle();

		write_reg(REG_NODE_COUNT, 32'd0);
		queue_item(32'h1000, 32'h10);
		queue_item(32'h0, 32'h0);
		settle();

		write_reg(REG_BASE_START, 32'h0);
		write_reg(REG_END_NODE0, 32'h7FFF_FFFF);
		write_reg(REG_END_NODE1, 32'hFFFF_FFFF);
		write_reg(REG_END_NODE2, 32'hFFFF_FFFF);
		write_reg(REG_END_NODE3, 32'hFFFF_FFFF);
		write_reg(REG_NODE_COUNT, 32'd4);
		write_reg(REG_LOCAL_NODE, 32'd2);
		queue_item(32'h0, 32'hFFFF_FFFF);
		queue_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		queue_item(32'h7FFF_FFFF, 32'h0);
		settle();

		write_reg(REG_BASE_START, 32'hFFFF_FFFF);
		write_reg(REG_NODE_COUNT, 32'd1);
		queue_item(32'hFFFF_FFFE, 32'h1);
		settle();

		for (ph = 0; ph < 6; ph++) begin
			random_setup();
			steady = (ph == 2);
			for (i = 0; i < 26; i++) begin
				r = random_req();
				queue_item(r.req_offset, r.req_size, ph == 3 && i == 15);
			end
			settle();
		end
		steady = 1'b0;

		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
